### design/llsg_pkg.sv
package llsg_pkg;

	// time base
	localparam int TIME_BITS_DEF = 48;
	localparam int NOW_W         = 48;

	// stream and config port widths
	localparam int MODE_W      = 2;
	localparam int TDATA_IN_W  = 56;
	localparam int TDATA_OUT_W = 40;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 27;

	// register and field widths
	localparam int TMO_W  = 27;
	localparam int MAXF_W = 4;
	localparam int LOCK_W = 22;
	localparam int FAIL_W = 4;
	localparam int MSG_W  = 3;
	localparam int LSEC_W = 12;
	localparam int SSEC_W = 17;

	// register reset values
	localparam logic [TMO_W-1:0]  TMO_RST  = 27'd1800000;
	localparam logic [MAXF_W-1:0] MAXF_RST = 4'd5;
	localparam logic [LOCK_W-1:0] LOCK_RST = 22'd30000;

	// remaining-time clamps, one below the ms value that maps to the field maximum
	localparam logic [LOCK_W-1:0] LOCK_CAP_M1 = 22'd4094999;
	localparam logic [TMO_W-1:0]  SESS_CAP_M1 = 27'd131070999;

	// divide by 1000: floor(x * DIV_M / 2^DIV_K) is exact for x < 2^DIV_X_W
	localparam int DIV_X_W = 28;
	localparam int DIV_M_W = 29;
	localparam int DIV_K   = 38;
	localparam logic [DIV_M_W-1:0] DIV_M = 29'd274877907;

	typedef enum logic [MODE_W-1:0] {
		MODE_QUERY   = 2'd0,
		MODE_ATTEMPT = 2'd1,
		MODE_LOGOUT  = 2'd2
	} mode_t;

	typedef enum logic [MSG_W-1:0] {
		MSG_LOCKED          = 3'd0,
		MSG_EXPIRED         = 3'd1,
		MSG_NOT_CONFIGURED  = 3'd2,
		MSG_AUTHENTICATED   = 3'd3,
		MSG_INVALID         = 3'd4,
		MSG_LOCKOUT_STARTED = 3'd5,
		MSG_CLOSED          = 3'd6
	} msg_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_SESSION_TIMEOUT = 2'd0,
		CFG_MAX_FAILURES    = 2'd1,
		CFG_LOCKOUT         = 2'd2
	} cfg_idx_t;

	// input word, lowest bits last
	typedef struct packed {
		logic [5:0]       pad;
		logic             password_matches;
		logic             credential_present;
		logic [NOW_W-1:0] now_ms;
	} in_word_t;

	// result word, lowest bits last
	typedef struct packed {
		logic [MSG_W-1:0]  message_code;
		logic [FAIL_W-1:0] failure_count;
		logic              attempt_ignored;
		logic [SSEC_W-1:0] session_seconds_left;
		logic [LSEC_W-1:0] lockout_seconds_left;
		logic              lock_active;
		logic              no_cred;
		logic              authorized;
	} res_word_t;

endpackage

### design/llsg_ceil_secs.sv
module llsg_ceil_secs
	import llsg_pkg::*;
#(
	parameter int IN_W  = LOCK_W,
	parameter int OUT_W = LSEC_W
) (
	input  logic [IN_W-1:0]  ms_m1,
	output logic [OUT_W-1:0] secs
);

	localparam int PROD_W = DIV_X_W + DIV_M_W;

	logic [PROD_W-1:0] prod;
	logic [OUT_W-1:0]  secs_floor;

	// ceil(d / 1000) == floor((d - 1) / 1000) + 1 for d >= 1
	assign prod       = PROD_W'(ms_m1) * PROD_W'(DIV_M);
	assign secs_floor = prod[DIV_K +: OUT_W];
	assign secs       = secs_floor + OUT_W'(1);

endmodule

### design/login_lockout_session_guard_core.sv
// A word passes the input register, stage 2, stage 3 and the result register to m_axis.
// Throughput: one word per cycle unless m_axis_tready stalls; lockout and session state
// update straight from the input register, so back-to-back words see each other's effect.
// The remaining-seconds divide is a constant reciprocal multiply in the last stage.
// Reset (arst_n low) clears session, failure count, lockout and message to their idle
// values, restores the register defaults and empties the pipeline.
module login_lockout_session_guard_core
	import llsg_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// now_ms[47:0], credential_present[48], password_matches[49], zero pad[55:50]
	input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
	// mode[1:0]
	input  logic [MODE_W-1:0]      s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// authorized[0], no_cred[1], lock_active[2], lockout_seconds_left[14:3],
	// session_seconds_left[31:15], attempt_ignored[32], failure_count[36:33],
	// message_code[39:37]
	output logic [TDATA_OUT_W-1:0] m_axis_tdata
);

	localparam int TB = TIME_BITS;
	localparam logic [TB-1:0] LOCK_CAP_T = {{(TB-LOCK_W){1'b0}}, LOCK_CAP_M1};
	localparam logic [TB-1:0] SESS_CAP_T = {{(TB-TMO_W){1'b0}}, SESS_CAP_M1};

	// configuration
	logic [TMO_W-1:0]  tmo_q;
	logic [MAXF_W-1:0] maxf_q;
	logic [LOCK_W-1:0] lockms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_q    <= TMO_RST;
			maxf_q   <= MAXF_RST;
			lockms_q <= LOCK_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_SESSION_TIMEOUT: tmo_q    <= cfg_wdata[TMO_W-1:0];
				CFG_MAX_FAILURES:    maxf_q   <= cfg_wdata[MAXF_W-1:0];
				CFG_LOCKOUT:         lockms_q <= cfg_wdata[LOCK_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline enables
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic en_s1, en_s2, en_s3, en_out;

	assign en_out        = !out_valid_q || m_axis_tready;
	assign en_s3         = !v_s3 || en_out;
	assign en_s2         = !v_s2 || en_s3;
	assign en_s1         = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	// stage 1: input register
	in_word_t         in_w;
	logic [63:0]      now_ext;
	mode_t            mode_s1;
	logic [TB-1:0]    now_s1;
	logic             cred_s1, match_s1;

	assign in_w    = in_word_t'(s_axis_tdata);
	assign now_ext = {{(64-NOW_W){1'b0}}, in_w.now_ms};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			mode_s1  <= mode_t'(s_axis_tuser);
			now_s1   <= now_ext[TB-1:0];
			cred_s1  <= in_w.credential_present;
			match_s1 <= in_w.password_matches;
		end
	end

	// guard state
	logic              sess_open_q;
	logic [TB-1:0]     sess_end_q;
	logic [FAIL_W-1:0] fail_q;
	logic [TB-1:0]     lock_end_q;
	msg_t              msg_q;

	logic              sess_exp, lock_exp, lock_pre;
	logic              so_n, ign_n;
	logic [TB-1:0]     se_n, le_n;
	logic [FAIL_W-1:0] f_exp, f_inc, f_n;
	msg_t              msg_n;
	logic [TB:0]       tmo_sum, lock_sum;
	logic [TB-1:0]     tmo_end, lock_end;

	assign sess_exp = sess_open_q && (now_s1 >= sess_end_q);
	assign lock_exp = (lock_end_q != '0) && (now_s1 >= lock_end_q);
	assign lock_pre = !lock_exp && (now_s1 < lock_end_q);
	assign f_exp    = lock_exp ? '0 : fail_q;
	assign f_inc    = f_exp + FAIL_W'(1);

	// end times saturate at the top of the time range
	assign tmo_sum  = {1'b0, now_s1} + (TB+1)'(tmo_q);
	assign lock_sum = {1'b0, now_s1} + (TB+1)'(lockms_q);
	assign tmo_end  = tmo_sum[TB] ? '1 : tmo_sum[TB-1:0];
	assign lock_end = lock_sum[TB] ? '1 : lock_sum[TB-1:0];

	always_comb begin
		so_n  = sess_exp ? 1'b0 : sess_open_q;
		se_n  = sess_exp ? '0 : sess_end_q;
		msg_n = sess_exp ? MSG_EXPIRED : msg_q;
		le_n  = lock_exp ? '0 : lock_end_q;
		f_n   = f_exp;
		ign_n = 1'b0;
		unique case (mode_s1)
			MODE_ATTEMPT: begin
				priority if (lock_pre) begin
					ign_n = 1'b1;
				end else if (!cred_s1) begin
					so_n  = 1'b0;
					se_n  = '0;
					msg_n = MSG_NOT_CONFIGURED;
				end else if (match_s1) begin
					so_n  = 1'b1;
					se_n  = tmo_end;
					f_n   = '0;
					le_n  = '0;
					msg_n = MSG_AUTHENTICATED;
				end else begin
					so_n = 1'b0;
					se_n = '0;
					if (f_inc >= maxf_q) begin
						f_n   = '0;
						le_n  = lock_end;
						msg_n = MSG_LOCKOUT_STARTED;
					end else begin
						f_n   = f_inc;
						msg_n = MSG_INVALID;
					end
				end
			end
			MODE_LOGOUT: begin
				so_n  = 1'b0;
				se_n  = '0;
				msg_n = MSG_CLOSED;
			end
			default: ;
		endcase
	end

	// advance state as the word leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_open_q <= 1'b0;
			sess_end_q  <= '0;
			fail_q      <= '0;
			lock_end_q  <= '0;
			msg_q       <= MSG_LOCKED;
		end else if (v_s1 && en_s2) begin
			sess_open_q <= so_n;
			sess_end_q  <= se_n;
			fail_q      <= f_n;
			lock_end_q  <= le_n;
			msg_q       <= msg_n;
		end
	end

	// stage 2: post-update state snapshot
	logic [TB-1:0]     now_s2, se_s2, le_s2;
	logic              cred_s2, so_s2, ign_s2;
	logic [FAIL_W-1:0] fail_s2;
	msg_t              msg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			now_s2  <= now_s1;
			se_s2   <= se_n;
			le_s2   <= le_n;
			cred_s2 <= cred_s1;
			so_s2   <= so_n;
			ign_s2  <= ign_n;
			fail_s2 <= f_n;
			msg_s2  <= msg_n;
		end
	end

	logic              auth_c, locked_c;
	logic [TB-1:0]     lm1, sm1;
	logic [LOCK_W-1:0] lx_c;
	logic [TMO_W-1:0]  sx_c;

	// end + ~now is end - now - 1
	assign auth_c   = cred_s2 && so_s2 && (now_s2 < se_s2);
	assign locked_c = now_s2 < le_s2;
	assign lm1      = le_s2 + ~now_s2;
	assign sm1      = se_s2 + ~now_s2;
	assign lx_c     = (lm1 > LOCK_CAP_T) ? LOCK_CAP_M1 : lm1[LOCK_W-1:0];
	assign sx_c     = (sm1 > SESS_CAP_T) ? SESS_CAP_M1 : sm1[TMO_W-1:0];

	// stage 3: flags and clamped remaining times
	logic              auth_s3, setup_s3, locked_s3, ign_s3;
	logic [FAIL_W-1:0] fail_s3;
	msg_t              msg_s3;
	logic [LOCK_W-1:0] lx_s3;
	logic [TMO_W-1:0]  sx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			auth_s3   <= auth_c;
			setup_s3  <= !cred_s2;
			locked_s3 <= locked_c;
			ign_s3    <= ign_s2;
			fail_s3   <= fail_s2;
			msg_s3    <= msg_s2;
			lx_s3     <= lx_c;
			sx_s3     <= sx_c;
		end
	end

	logic [LSEC_W-1:0] lsec;
	logic [SSEC_W-1:0] ssec;

	llsg_ceil_secs #(
		.IN_W  (LOCK_W),
		.OUT_W (LSEC_W)
	) u_lock_secs (
		.ms_m1 (lx_s3),
		.secs  (lsec)
	);

	llsg_ceil_secs #(
		.IN_W  (TMO_W),
		.OUT_W (SSEC_W)
	) u_sess_secs (
		.ms_m1 (sx_s3),
		.secs  (ssec)
	);

	// result register
	res_word_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s3) begin
			out_q.authorized           <= auth_s3;
			out_q.no_cred              <= setup_s3;
			out_q.lock_active          <= locked_s3;
			out_q.lockout_seconds_left <= locked_s3 ? lsec : '0;
			out_q.session_seconds_left <= auth_s3 ? ssec : '0;
			out_q.attempt_ignored      <= ign_s3;
			out_q.failure_count        <= fail_s3;
			out_q.message_code         <= msg_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// an ignored attempt only happens under an active lockout
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.attempt_ignored |-> out_q.lock_active)
		else $error("ignored attempt reported without lockout");

	// a locked result always has at least one second left, and none otherwise
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.lock_active == (out_q.lockout_seconds_left != '0)))
		else $error("lockout seconds disagree with lockout flag");

	// an open session needs a credential and has time left
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.authorized |->
			!out_q.no_cred && (out_q.session_seconds_left != '0))
		else $error("authorized result without credential or remaining time");

	// a successful login or a fresh lockout leaves the failure count cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.message_code == MSG_AUTHENTICATED ||
			out_q.message_code == MSG_LOCKOUT_STARTED) |-> (out_q.failure_count == '0))
		else $error("failure count not cleared");

endmodule
